[design/bcjd_pkg.sv]
// Package for the x86 branch/call address decoder.
// Holds the controller state type, the command/status structs, the opcode constants and the mask tables.
// Used by bcjd_ctrl, bcjd_dp and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package bcjd_pkg;

   localparam int unsigned WINDOW_DEPTH = 5;
   localparam int unsigned FILL_WIDTH   = 3;

   localparam logic [7:0]  OPCODE_MASK   = 8'hFE;
   localparam logic [7:0]  OPCODE_BASE   = 8'hE8;
   localparam logic [31:0] ADDRESS_BIAS  = 32'd5;
   localparam logic [31:0] OPCODE_NONE   = 32'hFFFF_FFFF;
   localparam logic [2:0]  OPERAND_SKIP  = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_ITERATE,
      ST_EMIT,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic load;
      logic decide;
      logic iterate;
      logic shift;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic fill_at_four;
      logic fill_at_one;
      logic convert;
      logic iter_done;
      logic last_pending;
   } status_type;

   function automatic logic is_ms_byte(input logic [7:0] value);
      return (value == 8'h00) || (value == 8'hFF);
   endfunction

   function automatic logic mask_allowed(input logic [2:0] mask);
      logic result;
      unique case (mask)
         3'd0, 3'd1, 3'd2, 3'd4: result = 1'b1;
         default:                result = 1'b0;
      endcase
      return result;
   endfunction

   function automatic logic [1:0] mask_bitnum(input logic [2:0] mask);
      logic [1:0] result;
      unique case (mask)
         3'd0:             result = 2'd0;
         3'd1:             result = 2'd1;
         3'd2, 3'd3:       result = 2'd2;
         default:          result = 2'd3;
      endcase
      return result;
   endfunction

endpackage
`default_nettype wire

[design/bcjd_ctrl.sv]
// Controller state machine of the x86 branch/call address decoder.
// Sequences load, decision, operand fix-up iterations and byte emission.
// Depends on bcjd_pkg; drives bcjd_dp through cmd_type and reads status_type.
`timescale 1ns / 1ps
`default_nettype none
module bcjd_ctrl
   import bcjd_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire        req_tlast,
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic       rsp_tlast,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      req_accept;
   logic      rsp_accept;

   assign req_accept = req_tvalid && (state_ff == ST_IDLE);
   assign rsp_accept = rsp_tready && ((state_ff == ST_EMIT) || (state_ff == ST_FLUSH));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && status.fill_at_four) begin
               state_in = ST_DECIDE;
            end else if (req_accept && req_tlast) begin
               state_in = ST_FLUSH;
            end
         end
         ST_DECIDE: begin
            state_in = status.convert ? ST_ITERATE : ST_EMIT;
         end
         ST_ITERATE: begin
            if (status.iter_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_accept) begin
               state_in = status.last_pending ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (rsp_accept && status.fill_at_one) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      rsp_tlast   = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_accept;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
         end
         ST_ITERATE: begin
            cmd.iterate = 1'b1;
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            cmd.shift  = rsp_accept;
         end
         ST_FLUSH: begin
            rsp_tvalid = 1'b1;
            rsp_tlast  = status.fill_at_one;
            cmd.shift  = rsp_accept;
            cmd.clear  = rsp_accept && status.fill_at_one;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[design/bcjd_dp.sv]
// Datapath of the x86 branch/call address decoder.
// Holds the five-byte window, offsets, opcode mask and the operand fix-up subtractor.
// Depends on bcjd_pkg; commanded by bcjd_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module bcjd_dp
   import bcjd_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire  [7:0]  req_data,
   input  wire         req_tlast,
   input  cmd_type     cmd,
   output status_type  status,
   output logic [7:0]  rsp_data
);

   logic [7:0]            window_ff [WINDOW_DEPTH];
   logic [7:0]            window_in [WINDOW_DEPTH];
   logic [FILL_WIDTH-1:0] fill_ff, fill_in;
   logic [31:0]           offset_ff, offset_in;
   logic [31:0]           last_op_ff, last_op_in;
   logic [2:0]            recent_ff, recent_in;
   logic [2:0]            skip_ff, skip_in;
   logic                  last_ff, last_in;
   logic [31:0]           src_ff, src_in;
   logic [31:0]           bias_ff, bias_in;
   logic [2:0]            fix_mask_ff, fix_mask_in;

   logic [31:0] op_distance;
   logic        near;
   logic [1:0]  shift_amount;
   logic [2:0]  m_dec;
   logic [7:0]  probe;
   logic        blocked;
   logic        is_opcode;
   logic [31:0] dest;
   logic [7:0]  check_byte;
   logic [31:0] keep_mask;
   logic        iter_done;

   always_comb begin
      op_distance  = offset_ff - last_op_ff;
      near         = (op_distance[31:2] == 30'd0) && (op_distance[1:0] != 2'd0);
      shift_amount = op_distance[1:0] - 2'd1;
      m_dec        = near ? 3'(recent_ff << shift_amount) : 3'd0;
      unique case (mask_bitnum(m_dec))
         2'd1:    probe = window_ff[3];
         2'd2:    probe = window_ff[2];
         2'd3:    probe = window_ff[1];
         default: probe = window_ff[4];
      endcase
      blocked   = (m_dec != 3'd0) && (!mask_allowed(m_dec) || is_ms_byte(probe));
      is_opcode = (window_ff[0] & OPCODE_MASK) == OPCODE_BASE;

      dest = src_ff - bias_ff;
      unique case (mask_bitnum(fix_mask_ff))
         2'd1: begin
            check_byte = dest[23:16];
            keep_mask  = 32'h00FF_FFFF;
         end
         2'd2: begin
            check_byte = dest[15:8];
            keep_mask  = 32'h0000_FFFF;
         end
         default: begin
            check_byte = dest[7:0];
            keep_mask  = 32'h0000_00FF;
         end
      endcase
      iter_done = (fix_mask_ff == 3'd0) || !is_ms_byte(check_byte);
   end

   assign status.fill_at_four = (fill_ff == FILL_WIDTH'(4));
   assign status.fill_at_one  = (fill_ff == FILL_WIDTH'(1));
   assign status.convert      = (skip_ff == 3'd0) && is_opcode && !blocked
                                && is_ms_byte(window_ff[4]);
   assign status.iter_done    = iter_done;
   assign status.last_pending = last_ff;
   assign rsp_data            = window_ff[0];

   always_comb begin
      window_in   = window_ff;
      fill_in     = fill_ff;
      offset_in   = offset_ff;
      last_op_in  = last_op_ff;
      recent_in   = recent_ff;
      skip_in     = skip_ff;
      last_in     = last_ff;
      src_in      = src_ff;
      bias_in     = bias_ff;
      fix_mask_in = fix_mask_ff;

      if (cmd.clear) begin
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            window_in[i] = 8'd0;
         end
         fill_in    = '0;
         offset_in  = 32'd0;
         last_op_in = OPCODE_NONE;
         recent_in  = 3'd0;
         skip_in    = 3'd0;
         last_in    = 1'b0;
      end else begin
         if (cmd.load) begin
            window_in[fill_ff] = req_data;
            fill_in            = fill_ff + FILL_WIDTH'(1);
            last_in            = req_tlast;
         end
         if (cmd.decide) begin
            if (skip_ff != 3'd0) begin
               skip_in = skip_ff - 3'd1;
            end else if (is_opcode) begin
               last_op_in = offset_ff;
               if (!blocked && is_ms_byte(window_ff[4])) begin
                  src_in      = {window_ff[4], window_ff[3], window_ff[2], window_ff[1]};
                  bias_in     = offset_ff + ADDRESS_BIAS;
                  fix_mask_in = m_dec;
               end else begin
                  recent_in = {m_dec[1:0], 1'b1};
               end
            end
         end
         if (cmd.iterate) begin
            if (iter_done) begin
               window_in[4] = dest[24] ? 8'hFF : 8'h00;
               window_in[3] = dest[23:16];
               window_in[2] = dest[15:8];
               window_in[1] = dest[7:0];
               skip_in      = OPERAND_SKIP;
               recent_in    = fix_mask_ff;
            end else begin
               src_in = dest ^ keep_mask;
            end
         end
         if (cmd.shift) begin
            for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
               window_in[i] = window_ff[i+1];
            end
            window_in[WINDOW_DEPTH-1] = 8'd0;
            fill_in   = fill_ff - FILL_WIDTH'(1);
            offset_in = offset_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            window_ff[i] <= 8'd0;
         end
         fill_ff    <= '0;
         offset_ff  <= 32'd0;
         last_op_ff <= OPCODE_NONE;
         recent_ff  <= 3'd0;
         skip_ff    <= 3'd0;
         last_ff    <= 1'b0;
      end else begin
         window_ff  <= window_in;
         fill_ff    <= fill_in;
         offset_ff  <= offset_in;
         last_op_ff <= last_op_in;
         recent_ff  <= recent_in;
         skip_ff    <= skip_in;
         last_ff    <= last_in;
      end
      src_ff      <= src_in;
      bias_ff     <= bias_in;
      fix_mask_ff <= fix_mask_in;
   end

endmodule
`default_nettype wire

[design/x86_branch_call_address_decoder_core.sv]
// Top level of the x86 branch/call address decoder (BCJ x86, decoding direction).
// Instantiates the controller bcjd_ctrl and the datapath bcjd_dp; depends on bcjd_pkg.
//
//   Channel   Direction  Payload
//   req_*     in         tdata[7:0] = data_byte, tlast = last_byte
//   rsp_*     out        tdata[7:0] = out_byte,  tlast = out_last
//
// One byte is handled at a time. A byte that fills the window passes through accept,
// decide, any operand fix-up iterations of the shared 32-bit subtractor, and emit;
// bytes before the window is full are only accepted.
// A final byte flushes the up to four held bytes at one per cycle while rsp is ready.
// Reset is synchronous and clears the window, offsets and opcode mask.
// A stall on rsp holds the emitted byte and blocks req until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module x86_branch_call_address_decoder_core
   import bcjd_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,   // [7:0] data_byte
   input  wire        req_tlast,
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast
);

   cmd_type    cmd;
   status_type status;

   bcjd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .status     (status),
      .cmd        (cmd)
   );

   bcjd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_tdata),
      .req_tlast (req_tlast),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_tdata)
   );

endmodule
`default_nettype wire

[design/bcjd_chk.sv]
// Port-level checker for the x86 branch/call address decoder top level.
// Bound to x86_branch_call_address_decoder_core; uses no package.
`timescale 1ns / 1ps
`default_nettype none
module bcjd_chk (
   input wire       clock,
   input wire       reset,
   input wire       req_tvalid,
   input wire       req_tready,
   input wire       req_tlast,
   input wire       rsp_tvalid,
   input wire       rsp_tready,
   input wire [7:0] rsp_tdata,
   input wire       rsp_tlast
);

   // A held response keeps its byte and marker.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

   // Requests and responses never overlap.
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("req_tready and rsp_tvalid high together");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // A final request leads to the decide or flush state, so no request is taken next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("request taken right after a final request");

   // The final response returns the block to accepting requests.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && !rsp_tvalid)
      else $error("block not idle after final response");

endmodule

bind x86_branch_call_address_decoder_core bcjd_chk u_bcjd_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
